// File: rtl/mfep_pkg.sv
// shared types, codes and helpers of the midi file event parser
// no dependencies
`default_nettype none

package mfep_pkg;

  localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_CTRL     = 3'd2;
  localparam logic [2:0] KIND_HEADER   = 3'd3;
  localparam logic [2:0] KIND_DONE     = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  localparam logic [2:0] ERR_HDR_MAGIC = 3'd0;
  localparam logic [2:0] ERR_HDR_LEN   = 3'd1;
  localparam logic [2:0] ERR_SMPTE     = 3'd2;
  localparam logic [2:0] ERR_TRK_MAGIC = 3'd3;
  localparam logic [2:0] ERR_LONG_VLQ  = 3'd4;
  localparam logic [2:0] ERR_OVERRUN   = 3'd5;
  localparam logic [2:0] ERR_NO_STATUS = 3'd6;
  localparam logic [2:0] ERR_TRUNC     = 3'd7;

  localparam logic [14:0] DEFAULT_TPQ = 15'd480;
  localparam int unsigned Q_DEPTH     = 4;
  localparam int unsigned Q_PTR_BITS  = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic        last_in_run;
    logic [47:0] tick;
    logic [3:0]  channel;
    logic [7:0]  note_or_controller;
    logic [7:0]  value;
    logic [15:0] file_format;
    logic [15:0] track_total;
    logic [14:0] ticks_per_quarter;
    logic [2:0]  error_code;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r1;
    res_t       r0;
  } res_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic res_pair_t add_res(input res_pair_t p, input res_t r);
    res_pair_t o;
    o = p;
    if (p.n == 2'd0) begin
      o.r0 = r;
      o.n  = 2'd1;
    end else if (p.n == 2'd1) begin
      o.r1 = r;
      o.n  = 2'd2;
    end
    return o;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind);
    res_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic logic [7:0] head_magic(input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = 8'h4D;
      2'd1:    v = 8'h54;
      2'd2:    v = 8'h68;
      default: v = 8'h64;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] trk_magic(input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = 8'h4D;
      2'd1:    v = 8'h54;
      2'd2:    v = 8'h72;
      default: v = 8'h6B;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mfep_byte_if.sv
// byte input channel of the midi file event parser
// no dependencies
`default_nettype none

interface mfep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// File: rtl/mfep_evt_if.sv
// event output channel of the midi file event parser
// no dependencies
`default_nettype none

interface mfep_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        last_in_run;
  logic [47:0] tick;
  logic [3:0]  channel;
  logic [7:0]  note_or_controller;
  logic [7:0]  value;
  logic [15:0] file_format;
  logic [15:0] track_total;
  logic [14:0] ticks_per_quarter;
  logic [2:0]  error_code;
  modport source (output valid, output kind, output last_in_run, output tick,
                  output channel, output note_or_controller, output value,
                  output file_format, output track_total, output ticks_per_quarter,
                  output error_code, input ready);
  modport sink (input valid, input kind, input last_in_run, input tick,
                input channel, input note_or_controller, input value,
                input file_format, input track_total, input ticks_per_quarter,
                input error_code, output ready);
endinterface

`default_nettype wire

// File: rtl/mfep_front.sv
// byte parser: header, chunk and track body state, builds up to two results per byte
// depends on mfep_pkg
`default_nettype none

module mfep_front #(
  parameter int unsigned TICK_BITS = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [14:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 end_of_file_i,
  output logic                      in_ready_o,
  input  wire mfep_pkg::q_stat_t    q_stat_i,
  output logic                      push_o,
  output mfep_pkg::res_pair_t       pair_o
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_CHUNK, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
    PH_META_LEN, PH_SYSEX_LEN, PH_SKIP, PH_SKIP_REST, PH_DONE, PH_ERROR
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [3:0]             idx_q, idx_d;
  logic [47:0]            words_q, words_d;
  logic [15:0]            tracks_q, tracks_d;
  logic [31:0]            bytes_q, bytes_d;
  logic [TICK_BITS-1:0]   tick_q, tick_d;
  logic [7:0]             run_q, run_d;
  logic [7:0]             cur_q, cur_d;
  logic [27:0]            vlq_q, vlq_d;
  logic [2:0]             vcnt_q, vcnt_d;
  logic [7:0]             first_q, first_d;
  logic [31:0]            skip_q, skip_d;
  logic                   meta_end_q, meta_end_d;
  logic [14:0]            tpq_cfg_q;
  mfep_pkg::res_pair_t    pair;
  logic                   accept;
  logic [TICK_BITS:0]     tick_sum;

  function automatic logic one_data(input logic [7:0] s);
    return (s[7:4] == 4'hC) || (s[7:4] == 4'hD);
  endfunction

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (pair.n != 2'd0);
  assign pair_o     = pair;
  assign tick_sum   = {1'b0, tick_q} + (TICK_BITS + 1)'({vlq_q[20:0], data_byte_i[6:0]});

  always_comb begin
    mfep_pkg::res_t  r;
    logic [7:0]      b;
    logic [27:0]     vn;
    logic [2:0]      cn;
    logic [31:0]     bl;
    logic            bad;
    phase_d    = phase_q;
    idx_d      = idx_q;
    words_d    = words_q;
    tracks_d   = tracks_q;
    bytes_d    = bytes_q;
    tick_d     = tick_q;
    run_d      = run_q;
    cur_d      = cur_q;
    vlq_d      = vlq_q;
    vcnt_d     = vcnt_q;
    first_d    = first_q;
    skip_d     = skip_q;
    meta_end_d = meta_end_q;
    pair       = '0;
    b          = data_byte_i;
    vn         = {vlq_q[20:0], b[6:0]};
    cn         = vcnt_q + 3'd1;
    bl         = bytes_q - 32'd1;
    bad        = 1'b0;
    r          = '0;
    case (phase_q)
      PH_HEADER: begin
        if (idx_q < 4'd4) begin
          if (b != mfep_pkg::head_magic(idx_q[1:0])) begin
            r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
            r.error_code = mfep_pkg::ERR_HDR_MAGIC;
            bad = 1'b1;
          end
        end else if (idx_q < 4'd8) begin
          if (b != ((idx_q == 4'd7) ? 8'd6 : 8'd0)) begin
            r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
            r.error_code = mfep_pkg::ERR_HDR_LEN;
            bad = 1'b1;
          end
        end else begin
          words_d = {words_q[39:0], b};
          if (idx_q == 4'd12 && b[7]) begin
            r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
            r.error_code = mfep_pkg::ERR_SMPTE;
            bad = 1'b1;
          end
        end
        if (bad) begin
          pair    = mfep_pkg::add_res(pair, r);
          phase_d = PH_ERROR;
        end else begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd13) begin
            r = mfep_pkg::mk_res(mfep_pkg::KIND_HEADER);
            r.file_format       = words_d[47:32];
            r.track_total       = words_d[31:16];
            r.ticks_per_quarter = (words_d[15:0] != 16'd0) ? words_d[14:0] : tpq_cfg_q;
            pair     = mfep_pkg::add_res(pair, r);
            tracks_d = words_d[31:16];
            idx_d    = 4'd0;
            if (words_d[31:16] == 16'd0) begin
              pair    = mfep_pkg::add_res(pair, mfep_pkg::mk_res(mfep_pkg::KIND_DONE));
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_CHUNK;
            end
          end
        end
      end
      PH_CHUNK: begin
        if (idx_q < 4'd4) begin
          if (b != mfep_pkg::trk_magic(idx_q[1:0])) begin
            r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
            r.error_code = mfep_pkg::ERR_TRK_MAGIC;
            pair    = mfep_pkg::add_res(pair, r);
            phase_d = PH_ERROR;
            bad     = 1'b1;
          end
        end else begin
          bytes_d = {bytes_q[23:0], b};
        end
        if (!bad) begin
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd7) begin
            idx_d   = 4'd0;
            tick_d  = '0;
            run_d   = 8'd0;
            vlq_d   = 28'd0;
            vcnt_d  = 3'd0;
            phase_d = PH_DELTA;
            if (bytes_d == 32'd0) begin
              tracks_d = tracks_q - 16'd1;
              if (tracks_d == 16'd0) begin
                pair    = mfep_pkg::add_res(pair, mfep_pkg::mk_res(mfep_pkg::KIND_DONE));
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_CHUNK;
              end
            end
          end
        end
      end
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN,
      PH_SYSEX_LEN, PH_SKIP, PH_SKIP_REST: begin
        bytes_d = bl;
        case (phase_q)
          PH_DELTA: begin
            vlq_d  = vn;
            vcnt_d = cn;
            if (b[7]) begin
              if (cn >= 3'd4) begin
                r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
                r.error_code = mfep_pkg::ERR_LONG_VLQ;
                pair    = mfep_pkg::add_res(pair, r);
                phase_d = PH_ERROR;
              end
            end else begin
              vcnt_d  = 3'd0;
              vlq_d   = 28'd0;
              tick_d  = tick_sum[TICK_BITS] ? '1 : tick_sum[TICK_BITS-1:0];
              phase_d = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (b[7]) begin
              cur_d = b;
              if (b < 8'hF0) run_d = b;
              if (b == 8'hFF) begin
                phase_d = PH_META_TYPE;
              end else if (b == 8'hF0 || b == 8'hF7) begin
                meta_end_d = 1'b0;
                phase_d    = PH_SYSEX_LEN;
              end else begin
                phase_d = PH_DATA1;
              end
            end else if (run_q == 8'd0) begin
              r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
              r.error_code = mfep_pkg::ERR_NO_STATUS;
              pair    = mfep_pkg::add_res(pair, r);
              phase_d = PH_ERROR;
            end else begin
              cur_d   = run_q;
              first_d = b;
              phase_d = one_data(run_q) ? PH_DELTA : PH_DATA2;
            end
          end
          PH_DATA1: begin
            first_d = b;
            phase_d = one_data(cur_q) ? PH_DELTA : PH_DATA2;
          end
          PH_DATA2: begin
            bad = 1'b1;
            if (cur_q[7:4] == 4'h9 && b != 8'd0) begin
              r = mfep_pkg::mk_res(mfep_pkg::KIND_NOTE_ON);
              r.value = b;
            end else if (cur_q[7:4] == 4'h8 || cur_q[7:4] == 4'h9) begin
              r = mfep_pkg::mk_res(mfep_pkg::KIND_NOTE_OFF);
            end else if (cur_q[7:4] == 4'hB) begin
              r = mfep_pkg::mk_res(mfep_pkg::KIND_CTRL);
              r.value = b;
            end else begin
              bad = 1'b0;
            end
            if (bad) begin
              r.tick               = 48'(tick_q);
              r.channel            = cur_q[3:0];
              r.note_or_controller = first_q;
              pair = mfep_pkg::add_res(pair, r);
            end
            phase_d = PH_DELTA;
          end
          PH_META_TYPE: begin
            meta_end_d = (b == 8'h2F);
            phase_d    = PH_META_LEN;
          end
          PH_META_LEN, PH_SYSEX_LEN: begin
            vlq_d  = vn;
            vcnt_d = cn;
            if (b[7]) begin
              if (cn >= 3'd4) begin
                r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
                r.error_code = mfep_pkg::ERR_LONG_VLQ;
                pair    = mfep_pkg::add_res(pair, r);
                phase_d = PH_ERROR;
              end
            end else begin
              vcnt_d = 3'd0;
              vlq_d  = 28'd0;
              if ({4'd0, vn} > bl) begin
                r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
                r.error_code = mfep_pkg::ERR_OVERRUN;
                pair    = mfep_pkg::add_res(pair, r);
                phase_d = PH_ERROR;
              end else begin
                skip_d = {4'd0, vn};
                if (vn != 28'd0) phase_d = PH_SKIP;
                else phase_d = meta_end_q ? PH_SKIP_REST : PH_DELTA;
              end
            end
          end
          PH_SKIP: begin
            skip_d = skip_q - 32'd1;
            if (skip_d == 32'd0) phase_d = meta_end_q ? PH_SKIP_REST : PH_DELTA;
          end
          default: begin
          end
        endcase
        if (phase_d != PH_ERROR && bl == 32'd0) begin
          if ((phase_d == PH_DELTA && vcnt_d == 3'd0) || phase_d == PH_SKIP_REST) begin
            tracks_d = tracks_q - 16'd1;
            if (tracks_d == 16'd0) begin
              pair    = mfep_pkg::add_res(pair, mfep_pkg::mk_res(mfep_pkg::KIND_DONE));
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_CHUNK;
              idx_d   = 4'd0;
            end
          end else begin
            r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
            r.error_code = mfep_pkg::ERR_OVERRUN;
            pair    = mfep_pkg::add_res(pair, r);
            phase_d = PH_ERROR;
          end
        end
      end
      default: begin
      end
    endcase
    if (end_of_file_i && phase_d != PH_DONE && phase_d != PH_ERROR) begin
      r = mfep_pkg::mk_res(mfep_pkg::KIND_ERROR);
      r.error_code = (phase_d == PH_HEADER || phase_d == PH_CHUNK) ?
                     mfep_pkg::ERR_TRUNC : mfep_pkg::ERR_OVERRUN;
      pair    = mfep_pkg::add_res(pair, r);
      phase_d = PH_ERROR;
    end
    if (pair.n == 2'd1) pair.r0.last_in_run = 1'b1;
    if (pair.n == 2'd2) pair.r1.last_in_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      idx_q      <= '0;
      words_q    <= '0;
      tracks_q   <= '0;
      bytes_q    <= '0;
      tick_q     <= '0;
      run_q      <= '0;
      cur_q      <= '0;
      vlq_q      <= '0;
      vcnt_q     <= '0;
      first_q    <= '0;
      skip_q     <= '0;
      meta_end_q <= 1'b0;
      tpq_cfg_q  <= mfep_pkg::DEFAULT_TPQ;
    end else begin
      if (cfg_we_i) tpq_cfg_q <= cfg_wdata_i;
      if (accept) begin
        phase_q    <= phase_d;
        idx_q      <= idx_d;
        words_q    <= words_d;
        tracks_q   <= tracks_d;
        bytes_q    <= bytes_d;
        tick_q     <= tick_d;
        run_q      <= run_d;
        cur_q      <= cur_d;
        vlq_q      <= vlq_d;
        vcnt_q     <= vcnt_d;
        first_q    <= first_d;
        skip_q     <= skip_d;
        meta_end_q <= meta_end_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mfep_queue.sv
// short queue of per-byte result groups between parser and output side
// depends on mfep_pkg
`default_nettype none

module mfep_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire mfep_pkg::res_pair_t  pair_i,
  input  wire logic                 pop_i,
  output mfep_pkg::res_pair_t       head_o,
  output mfep_pkg::q_stat_t         stat_o
);

  mfep_pkg::res_pair_t                 mem_q [mfep_pkg::Q_DEPTH];
  logic [mfep_pkg::Q_PTR_BITS-1:0]     wr_q, rd_q;
  logic [mfep_pkg::Q_PTR_BITS:0]       cnt_q;

  assign stat_o.full  = (cnt_q == (mfep_pkg::Q_PTR_BITS + 1)'(mfep_pkg::Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (mfep_pkg::Q_PTR_BITS + 1)'(mfep_pkg::Q_DEPTH)) else $error("count overflow");
  a_nonempty_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> pair_i.n != 2'd0) else $error("empty group pushed");
`endif

endmodule

`default_nettype wire

// File: rtl/mfep_back.sv
// output side: sends the one or two results of each queued group in order
// depends on mfep_pkg
`default_nettype none

module mfep_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mfep_pkg::res_pair_t  head_i,
  input  wire mfep_pkg::q_stat_t    q_stat_i,
  output logic                      pop_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output mfep_pkg::res_t            res_o
);

  logic sel_q;
  logic take;

  assign out_valid_o = !q_stat_i.empty;
  assign res_o       = sel_q ? head_i.r1 : head_i.r0;
  assign take        = out_valid_o && out_ready_i;
  assign pop_o       = take && (sel_q || head_i.n != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (take) begin
      sel_q <= !pop_o;
    end
  end

endmodule

`default_nettype wire

// File: rtl/midi_file_event_parser.sv
// top level of the midi file event parser: parser, result queue and output side
// depends on mfep_pkg, mfep_byte_if, mfep_evt_if, mfep_front, mfep_queue, mfep_back
//
// usage
//   byte_in carries one file byte per request, end_of_file set on the last byte
//   evt_out carries results: note on/off, control change, header, done, error
//   cfg_we_i/cfg_wdata_i set the ticks per quarter used when the header division is zero
// timing
//   one byte accepted per cycle while the result queue is not full; each byte is parsed
//   in the cycle it is accepted; evt_out gives one result per cycle while ready is high
//   a byte giving two results holds the output side until both have been taken
// backpressure
//   a four-entry queue of result groups sits between parser and output side
//   byte_in.ready drops only while that queue is full
// reset
//   rst_ni clears parse state to the header phase and empties the queue
//   the division register returns to 480
//   after done or error all further bytes are taken and dropped until reset
`default_nettype none

module midi_file_event_parser #(
  parameter int unsigned TICK_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [14:0] cfg_wdata_i,
  mfep_byte_if.sink        byte_in,
  mfep_evt_if.source       evt_out
);

  mfep_pkg::res_pair_t pair;
  mfep_pkg::res_pair_t head;
  mfep_pkg::q_stat_t   q_stat;
  mfep_pkg::res_t      res;
  logic                push;
  logic                pop;
  logic                in_ready;
  logic                out_valid;

  mfep_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (byte_in.valid),
    .data_byte_i   (byte_in.data_byte),
    .end_of_file_i (byte_in.end_of_file),
    .in_ready_o    (in_ready),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .pair_o        (pair)
  );

  mfep_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pair_i (pair),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  mfep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_ready_i (evt_out.ready),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  assign byte_in.ready              = in_ready;
  assign evt_out.valid              = out_valid;
  assign evt_out.kind               = res.kind;
  assign evt_out.last_in_run        = res.last_in_run;
  assign evt_out.tick               = res.tick;
  assign evt_out.channel            = res.channel;
  assign evt_out.note_or_controller = res.note_or_controller;
  assign evt_out.value              = res.value;
  assign evt_out.file_format        = res.file_format;
  assign evt_out.track_total        = res.track_total;
  assign evt_out.ticks_per_quarter  = res.ticks_per_quarter;
  assign evt_out.error_code         = res.error_code;

endmodule

`default_nettype wire

// File: bench/tb_midi_file_event_parser.sv
// self-checking bench for midi_file_event_parser: builds one midi file per run with
// random tracks and a random ending, predicts every event and compares in order
// depends on mfep_pkg, mfep_byte_if, mfep_evt_if and the rtl top level
`timescale 1ns / 1ps

module tb_midi_file_event_parser;

  typedef enum logic [3:0] {
    P_HEADER, P_CHUNK, P_DELTA, P_STATUS, P_DATA1, P_DATA2, P_META_TYPE,
    P_META_LEN, P_SYSEX_LEN, P_SKIP, P_SKIP_REST, P_DONE, P_ERROR
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] b;
    logic       eof;
  } file_byte_t;

  localparam logic [47:0] TICK_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam int          IDLE_LIMIT = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [14:0] cfg_wdata_i;

  mfep_byte_if byte_if ();
  mfep_evt_if  evt_if ();

  midi_file_event_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_in     (byte_if),
    .evt_out     (evt_if)
  );

  file_byte_t      byte_q[$];
  mfep_pkg::res_t  event_q[$];
  int              err_cnt;
  int              idle_cycles;
  bit              busy;
  int              burst_left;
  int              gap_left;
  int              stall_mode;
  int              stall_cnt;

  // predictor state
  logic [14:0]  tpq_reg;
  parse_phase_e ph;
  logic [3:0]   hidx;
  logic [47:0]  hwords;
  logic [15:0]  tracks_left;
  logic [31:0]  chunk_left;
  logic [47:0]  abs_tick;
  logic [7:0]   run_status;
  logic [7:0]   cur_status;
  logic [27:0]  vlq_acc;
  int           vlq_cnt;
  logic [7:0]   data1;
  logic [31:0]  skip_left;
  bit           meta_end;
  int           step_events;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_event(input mfep_pkg::res_t r);
    event_q.insert(event_q.size(), r);
    step_events++;
  endfunction

  function automatic void parse_fail(input logic [2:0] code);
    mfep_pkg::res_t r;
    r = '0;
    r.kind = mfep_pkg::KIND_ERROR;
    r.error_code = code;
    add_event(r);
    ph = P_ERROR;
  endfunction

  function automatic void close_track();
    mfep_pkg::res_t r;
    r = '0;
    tracks_left = tracks_left - 16'd1;
    if (tracks_left == 16'd0) begin
      r.kind = mfep_pkg::KIND_DONE;
      add_event(r);
      ph = P_DONE;
    end else begin
      ph = P_CHUNK;
      hidx = '0;
    end
  endfunction

  function automatic int take_vlq(input logic [7:0] b);
    vlq_acc = {vlq_acc[20:0], b[6:0]};
    vlq_cnt++;
    if (b[7]) begin
      if (vlq_cnt >= 4) begin
        parse_fail(mfep_pkg::ERR_LONG_VLQ);
        return -1;
      end
      return 0;
    end
    vlq_cnt = 0;
    return 1;
  endfunction

  function automatic bit single_data();
    return cur_status[7:4] == 4'hC || cur_status[7:4] == 4'hD;
  endfunction

  function automatic void channel_event(input logic [7:0] d2);
    mfep_pkg::res_t r;
    r = '0;
    if (cur_status[7:4] == 4'h9 && d2 != 8'd0) begin
      r.kind = mfep_pkg::KIND_NOTE_ON;
      r.value = d2;
    end else if (cur_status[7:4] == 4'h8 || cur_status[7:4] == 4'h9) begin
      r.kind = mfep_pkg::KIND_NOTE_OFF;
    end else if (cur_status[7:4] == 4'hB) begin
      r.kind = mfep_pkg::KIND_CTRL;
      r.value = d2;
    end else begin
      return;
    end
    r.tick = abs_tick;
    r.channel = cur_status[3:0];
    r.note_or_controller = data1;
    add_event(r);
  endfunction

  function automatic void body_length_done();
    logic [31:0] len;
    len = {4'd0, vlq_acc};
    vlq_acc = '0;
    if (len > chunk_left) begin
      parse_fail(mfep_pkg::ERR_OVERRUN);
      return;
    end
    skip_left = len;
    if (len != 0) ph = P_SKIP;
    else ph = meta_end ? P_SKIP_REST : P_DELTA;
  endfunction

  function automatic void header_step(input logic [7:0] b);
    logic [7:0]     magic [4];
    int             k;
    mfep_pkg::res_t r;
    magic = '{8'h4D, 8'h54, 8'h68, 8'h64};
    k = int'(hidx);
    r = '0;
    if (k < 4) begin
      if (b != magic[k]) begin
        parse_fail(mfep_pkg::ERR_HDR_MAGIC);
        return;
      end
    end else if (k < 8) begin
      if (b != ((k == 7) ? 8'd6 : 8'd0)) begin
        parse_fail(mfep_pkg::ERR_HDR_LEN);
        return;
      end
    end else begin
      hwords = {hwords[39:0], b};
      if (k == 12 && b[7]) begin
        parse_fail(mfep_pkg::ERR_SMPTE);
        return;
      end
    end
    hidx = hidx + 4'd1;
    if (k == 13) begin
      r.kind = mfep_pkg::KIND_HEADER;
      r.file_format = hwords[47:32];
      r.track_total = hwords[31:16];
      r.ticks_per_quarter = (hwords[15:0] != 16'd0) ? hwords[14:0] : tpq_reg;
      add_event(r);
      tracks_left = hwords[31:16];
      hidx = '0;
      if (tracks_left == 16'd0) begin
        r = '0;
        r.kind = mfep_pkg::KIND_DONE;
        add_event(r);
        ph = P_DONE;
      end else begin
        ph = P_CHUNK;
      end
    end
  endfunction

  function automatic void chunk_step(input logic [7:0] b);
    logic [7:0] magic [4];
    int         k;
    magic = '{8'h4D, 8'h54, 8'h72, 8'h6B};
    k = int'(hidx);
    if (k < 4) begin
      if (b != magic[k]) begin
        parse_fail(mfep_pkg::ERR_TRK_MAGIC);
        return;
      end
    end else begin
      chunk_left = {chunk_left[23:0], b};
    end
    hidx = hidx + 4'd1;
    if (k == 7) begin
      hidx = '0;
      abs_tick = '0;
      run_status = '0;
      vlq_acc = '0;
      vlq_cnt = 0;
      ph = P_DELTA;
      if (chunk_left == 32'd0) close_track();
    end
  endfunction

  function automatic void body_step(input logic [7:0] b);
    logic [47:0] d;
    case (ph)
      P_DELTA: begin
        if (take_vlq(b) == 1) begin
          d = {20'd0, vlq_acc};
          vlq_acc = '0;
          abs_tick = (d > TICK_MAX - abs_tick) ? TICK_MAX : abs_tick + d;
          ph = P_STATUS;
        end
      end
      P_STATUS: begin
        if (b[7]) begin
          cur_status = b;
          if (b < 8'hF0) run_status = b;
          if (b == 8'hFF) ph = P_META_TYPE;
          else if (b == 8'hF0 || b == 8'hF7) begin
            meta_end = 1'b0;
            ph = P_SYSEX_LEN;
          end else ph = P_DATA1;
        end else if (run_status == 8'd0) begin
          parse_fail(mfep_pkg::ERR_NO_STATUS);
        end else begin
          cur_status = run_status;
          data1 = b;
          ph = single_data() ? P_DELTA : P_DATA2;
        end
      end
      P_DATA1: begin
        data1 = b;
        ph = single_data() ? P_DELTA : P_DATA2;
      end
      P_DATA2: begin
        channel_event(b);
        ph = P_DELTA;
      end
      P_META_TYPE: begin
        meta_end = (b == 8'h2F);
        ph = P_META_LEN;
      end
      P_META_LEN, P_SYSEX_LEN: begin
        if (take_vlq(b) == 1) body_length_done();
      end
      P_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) ph = meta_end ? P_SKIP_REST : P_DELTA;
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eof);
    step_events = 0;
    if (ph == P_HEADER) header_step(b);
    else if (ph == P_CHUNK) chunk_step(b);
    else if (ph >= P_DELTA && ph <= P_SKIP_REST) begin
      chunk_left = chunk_left - 32'd1;
      body_step(b);
      if (ph != P_ERROR && chunk_left == 32'd0) begin
        if ((ph == P_DELTA && vlq_cnt == 0) || ph == P_SKIP_REST) close_track();
        else parse_fail(mfep_pkg::ERR_OVERRUN);
      end
    end
    if (eof && ph != P_DONE && ph != P_ERROR)
      parse_fail((ph >= P_DELTA && ph <= P_SKIP_REST) ?
                 mfep_pkg::ERR_OVERRUN : mfep_pkg::ERR_TRUNC);
    if (step_events > 0) event_q[event_q.size() - 1].last_in_run = 1'b1;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // input side and prediction, config mirror, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tpq_reg = cfg_wdata_i;
      if (byte_if.valid && byte_if.ready) begin
        parse_byte(byte_if.data_byte, byte_if.end_of_file);
        busy = 1'b0;
      end
      if ((byte_if.valid && byte_if.ready) || (evt_if.valid && evt_if.ready) ||
          (byte_q.size() == 0 && !busy && event_q.size() == 0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    file_byte_t fb;
    if (rst_ni && !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        byte_if.valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        fb = byte_q.pop_front();
        byte_if.data_byte <= fb.b;
        byte_if.end_of_file <= fb.eof;
        byte_if.valid <= 1'b1;
        busy = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    stall_cnt++;
    if (stall_cnt >= 50) begin
      stall_cnt = 0;
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: evt_if.ready <= 1'b1;
      1: evt_if.ready <= 1'($urandom_range(0, 1));
      2: evt_if.ready <= ($urandom_range(0, 3) == 0);
      default: evt_if.ready <= ((stall_cnt % 8) < 5);
    endcase
  end

  always @(posedge clk_i) begin
    mfep_pkg::res_t want;
    if (rst_ni && evt_if.valid && evt_if.ready) begin
      if (event_q.size() == 0) begin
        report("unexpected event kind", 64'(evt_if.kind), 64'd0);
      end else begin
        want = event_q.pop_front();
        if (evt_if.kind !== want.kind) report("kind", 64'(evt_if.kind), 64'(want.kind));
        if (evt_if.last_in_run !== want.last_in_run)
          report("last_in_run", 64'(evt_if.last_in_run), 64'(want.last_in_run));
        if (evt_if.tick !== want.tick) report("tick", 64'(evt_if.tick), 64'(want.tick));
        if (evt_if.channel !== want.channel)
          report("channel", 64'(evt_if.channel), 64'(want.channel));
        if (evt_if.note_or_controller !== want.note_or_controller)
          report("note_or_controller", 64'(evt_if.note_or_controller),
                 64'(want.note_or_controller));
        if (evt_if.value !== want.value) report("value", 64'(evt_if.value), 64'(want.value));
        if (evt_if.file_format !== want.file_format)
          report("file_format", 64'(evt_if.file_format), 64'(want.file_format));
        if (evt_if.track_total !== want.track_total)
          report("track_total", 64'(evt_if.track_total), 64'(want.track_total));
        if (evt_if.ticks_per_quarter !== want.ticks_per_quarter)
          report("ticks_per_quarter", 64'(evt_if.ticks_per_quarter),
                 64'(want.ticks_per_quarter));
        if (evt_if.error_code !== want.error_code)
          report("error_code", 64'(evt_if.error_code), 64'(want.error_code));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    file_byte_t fb;
    fb.b = b;
    fb.eof = 1'b0;
    byte_q.insert(byte_q.size(), fb);
  endtask

  task automatic put_vlq(ref logic [7:0] q[$], input logic [27:0] v);
    logic [7:0] grp[$];
    grp.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (grp[i]) q.insert(q.size(), grp[i]);
  endtask

  function automatic logic [27:0] pick_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 28'($urandom_range(0, 127));
    if (r < 9) return 28'($urandom_range(0, 16383));
    return 28'($urandom_range(0, 28'h0FFF_FFFF));
  endfunction

  task automatic put_random_event(ref logic [7:0] q[$], ref logic [7:0] rs);
    int         sel;
    int         len;
    logic [7:0] st;
    logic [3:0] ch;
    sel = $urandom_range(0, 99);
    ch = 4'($urandom_range(0, 15));
    if (sel >= 68 && sel < 78 && rs == 8'd0) sel = 0;
    put_vlq(q, pick_delta());
    if (sel < 62 || (sel >= 62 && sel < 68)) begin
      if (sel < 30) st = {4'h9, ch};
      else if (sel < 40) st = {4'h8, ch};
      else if (sel < 55) st = {4'hB, ch};
      else if (sel < 62) st = {$urandom_range(0, 1) ? 4'hC : 4'hD, ch};
      else st = {$urandom_range(0, 1) ? 4'hA : 4'hE, ch};
      rs = st;
      q.insert(q.size(), st);
      q.insert(q.size(), 8'($urandom_range(0, 255)));
      if (st[7:4] != 4'hC && st[7:4] != 4'hD)
        q.insert(q.size(), ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
    end else if (sel < 78) begin
      q.insert(q.size(), 8'($urandom_range(0, 127)));
      if (rs[7:4] != 4'hC && rs[7:4] != 4'hD)
        q.insert(q.size(), ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
    end else if (sel < 90) begin
      if (sel < 85) begin
        q.insert(q.size(), 8'hFF);
        st = 8'($urandom_range(0, 127));
        q.insert(q.size(), (st == 8'h2F) ? 8'h01 : st);
      end else begin
        q.insert(q.size(), $urandom_range(0, 1) ? 8'hF0 : 8'hF7);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 140) : $urandom_range(0, 5);
      put_vlq(q, 28'(len));
      repeat (len) q.insert(q.size(), 8'($urandom_range(0, 255)));
    end else begin
      st = 8'($urandom_range(8'hF1, 8'hFE));
      if (st == 8'hF7) st = 8'hF1;
      q.insert(q.size(), st);
      q.insert(q.size(), 8'($urandom_range(0, 255)));
      q.insert(q.size(), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_directed(ref logic [7:0] q[$]);
    q = '{8'h00, 8'h90, 8'h00, 8'hFF,
          8'h00, 8'h90, 8'h7F, 8'h00,
          8'h05, 8'h8F, 8'hFF, 8'hFF,
          8'h00, 8'hB3, 8'h07, 8'h64,
          8'h01, 8'hC2, 8'h05,
          8'h00, 8'hD4, 8'h40,
          8'h00, 8'hA1, 8'h10, 8'h20,
          8'h00, 8'hE1, 8'h00, 8'h40,
          8'h00, 8'h9A, 8'h3C, 8'h40,
          8'h00, 8'h3E, 8'h50,
          8'h00, 8'hFF, 8'h01, 8'h03, 8'h41, 8'h42, 8'h43,
          8'h00, 8'hF0, 8'h02, 8'h7E, 8'hF7,
          8'h00, 8'hF3, 8'h01, 8'h02,
          8'h40, 8'h00, 8'h00};
    put_vlq(q, 28'h0FFF_FFFF);
    q.insert(q.size(), 8'hB0);
    q.insert(q.size(), 8'h80);
    q.insert(q.size(), 8'hFF);
  endtask

  task automatic push_chunk(ref logic [7:0] body[$], input logic [31:0] len, input bit good);
    push_byte(8'h4D);
    push_byte(8'h54);
    push_byte(8'h72);
    push_byte(good ? 8'h6B : 8'h6A);
    push_byte(len[31:24]);
    push_byte(len[23:16]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    foreach (body[i]) push_byte(body[i]);
  endtask

  task automatic write_tpq(input logic [14:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || busy || event_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  body[$];
    logic [7:0]  hdr[14];
    logic [7:0]  rs;
    logic [15:0] ntrk;
    logic [15:0] div;
    file_byte_t  fb;
    int          ending;
    int          ngen;
    int          cut;
    logic [14:0] tpq_pick;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.end_of_file = 1'b0;
    evt_if.ready = 1'b0;
    err_cnt = 0;
    idle_cycles = 0;
    busy = 1'b0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    stall_cnt = 0;
    tpq_reg = mfep_pkg::DEFAULT_TPQ;
    ph = P_HEADER;
    hidx = '0;
    hwords = '0;
    tracks_left = '0;
    chunk_left = '0;
    abs_tick = '0;
    run_status = '0;
    cur_status = '0;
    vlq_acc = '0;
    vlq_cnt = 0;
    data1 = '0;
    skip_left = '0;
    meta_end = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_tpq($urandom_range(0, 1) ? 15'h7FFF : 15'd1);

    ending = $urandom_range(0, 15);
    ending = (ending < 8) ? 0 : ending - 7;
    ngen = $urandom_range(6, 9);
    ntrk = 16'(ngen);
    if (ending == 8 && $urandom_range(0, 1)) ntrk = 16'd0;
    else if (ending != 0 && $urandom_range(0, 3) == 0) ntrk = 16'hFFFF;
    div = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 16'h7FFF));
    hdr = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
            8'h00, 8'h00, ntrk[15:8], ntrk[7:0], div[15:8], div[7:0]};
    hdr[9] = 8'($urandom_range(0, 2));
    if (ending == 8 && ntrk != 16'd0) begin
      cut = $urandom_range(0, 12);
      hdr[cut] = (cut == 12) ? 8'($urandom_range(8'h80, 8'hFF)) : 8'($urandom_range(0, 255));
    end
    foreach (hdr[i]) push_byte(hdr[i]);

    if (ending != 8) begin
      for (int t = 0; t < ngen; t++) begin
        rs = 8'd0;
        body.delete();
        if (t == 0) build_directed(body);
        else if ($urandom_range(0, 7) != 0 || t == ngen - 1)
          repeat ($urandom_range(3, 11)) put_random_event(body, rs);
        if (body.size() != 0 && $urandom_range(0, 1)) begin
          body.insert(body.size(), 8'h00);
          body.insert(body.size(), 8'hFF);
          body.insert(body.size(), 8'h2F);
          cut = $urandom_range(0, 2);
          body.insert(body.size(), 8'(cut));
          repeat (cut + $urandom_range(0, 3)) body.insert(body.size(), 8'($urandom_range(0, 255)));
        end
        if (t < ngen - 1 || ending == 0) begin
          push_chunk(body, 32'(body.size()), 1'b1);
        end else begin
          case (ending)
            1: begin
              push_chunk(body, 32'(body.size()), 1'b1);
              repeat ($urandom_range(1, body.size())) void'(byte_q.pop_back());
            end
            2: begin
              body = '{8'h00, 8'h40, 8'h40};
              push_chunk(body, 32'(body.size()), 1'b1);
            end
            3: begin
              body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
              push_chunk(body, 32'(body.size()), 1'b1);
            end
            4: push_chunk(body, 32'(body.size()), 1'b0);
            5: begin
              push_chunk(body, 32'(body.size()), 1'b1);
              repeat (body.size() + $urandom_range(1, 5)) void'(byte_q.pop_back());
            end
            6: push_chunk(body, 32'(body.size() - $urandom_range(1, body.size())), 1'b1);
            default: begin
              body = '{8'h00, 8'hFF, 8'h01, 8'h7F};
              push_chunk(body, 32'(body.size()), 1'b1);
            end
          endcase
        end
        if (t == ngen - 1) begin
          fb = byte_q.pop_back();
          fb.eof = 1'b1;
          byte_q.insert(byte_q.size(), fb);
        end
        wait_drained();
        case ($urandom_range(0, 3))
          0: tpq_pick = 15'd1;
          1: tpq_pick = 15'h7FFF;
          2: tpq_pick = 15'd480;
          default: tpq_pick = 15'($urandom_range(0, 15'h7FFF));
        endcase
        write_tpq(tpq_pick);
      end
    end else if ($urandom_range(0, 1)) begin
      cut = $urandom_range(1, 13);
      repeat (cut) void'(byte_q.pop_back());
      fb = byte_q.pop_back();
      fb.eof = 1'b1;
      byte_q.insert(byte_q.size(), fb);
    end

    repeat ((ending == 8) ? $urandom_range(360, 420) : $urandom_range(4, 12)) begin
      fb.b = 8'($urandom_range(0, 255));
      fb.eof = 1'($urandom_range(0, 1));
      byte_q.insert(byte_q.size(), fb);
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
